FILE: hdl/pbs_pkg.sv
// Shared constants, microcode word type and control program for the pattern bilinear sampler.
// No dependencies; used by pbs_ram-based top level and its checker by scoped names.
package pbs_pkg;

	localparam int MAX_COLS  = 512;
	localparam int MAX_ROWS  = 512;
	localparam int FRAC_BITS = 6;

	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int BANK_AW    = (COL_W - 1) + (ROW_W - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;

	localparam int CFG_W   = 10;
	localparam int PIX_W   = 8;
	localparam int PIDX_W  = 9;
	localparam int COORD_W = 17;
	localparam int INT_W   = COORD_W - FRAC_BITS;
	localparam int TAPI_W  = INT_W + 1;
	localparam int EXT_W   = (TAPI_W > 13 ? TAPI_W : 13) + 1;

	localparam int FW_W   = FRAC_BITS + 1;
	localparam int WGT_W  = 2 * FRAC_BITS + 1;
	localparam int PROD_W = WGT_W + PIX_W;
	localparam int TAP_W  = PROD_W;
	localparam int ACC_W  = TAP_W + 4;

	localparam int OUT_W    = 24;
	localparam int OUT_FRAC = 16;
	localparam int ACC_FRAC = 2 * FRAC_BITS + 4;
	localparam int RES_SHL  = (OUT_FRAC >= ACC_FRAC) ? OUT_FRAC - ACC_FRAC : 0;
	localparam int RES_SHR  = (ACC_FRAC > OUT_FRAC) ? ACC_FRAC - OUT_FRAC : 0;
	localparam int RES_W    = ACC_W + RES_SHL;
	localparam int OUT_MAX  = 16711680;

	localparam int IN_TDATA_W = 64;
	localparam int ROW_LSB    = 0;
	localparam int COL_LSB    = ROW_LSB + PIDX_W;
	localparam int VAL_LSB    = COL_LSB + PIDX_W;
	localparam int X_LSB      = VAL_LSB + PIX_W;
	localparam int Y_LSB      = X_LSB + COORD_W;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_EMIT = STEP_W'(12);

	typedef enum logic [1:0] {
		COND_NEXT,
		COND_START,
		COND_OUT,
		COND_JUMP
	} cond_t;

	typedef enum logic {
		REG_IMAGE_COLS = 1'b0,
		REG_IMAGE_ROWS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic              issue;
		logic              centre;
		logic signed [2:0] dx;
		logic signed [2:0] dy;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	// Program: wait for a sample, issue the centre tap and eight neighbors,
	// drain the read and multiply stages, then hand the sum to the output.
	function automatic uword_t ucode(logic [STEP_W-1:0] step);
		uword_t w;
		w        = '0;
		w.cond   = COND_NEXT;
		w.target = STEP_IDLE;
		case (step)
			4'd0: begin
				w.cond = COND_START;
			end
			4'd1: begin
				w.issue  = 1'b1;
				w.centre = 1'b1;
			end
			4'd2: begin
				w.issue = 1'b1; w.dx = 3'sd0;  w.dy = -3'sd2;
			end
			4'd3: begin
				w.issue = 1'b1; w.dx = -3'sd1; w.dy = -3'sd1;
			end
			4'd4: begin
				w.issue = 1'b1; w.dx = 3'sd1;  w.dy = -3'sd1;
			end
			4'd5: begin
				w.issue = 1'b1; w.dx = -3'sd2; w.dy = 3'sd0;
			end
			4'd6: begin
				w.issue = 1'b1; w.dx = 3'sd2;  w.dy = 3'sd0;
			end
			4'd7: begin
				w.issue = 1'b1; w.dx = -3'sd1; w.dy = 3'sd1;
			end
			4'd8: begin
				w.issue = 1'b1; w.dx = 3'sd1;  w.dy = 3'sd1;
			end
			4'd9: begin
				w.issue = 1'b1; w.dx = 3'sd0;  w.dy = 3'sd2;
			end
			4'd10, 4'd11: begin
				w.cond = COND_NEXT;
			end
			STEP_EMIT: begin
				w.cond   = COND_OUT;
				w.target = STEP_IDLE;
			end
			default: begin
				w.cond   = COND_JUMP;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: hdl/pbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/pattern_bilinear_sampler_top.sv
// Top level of the pattern bilinear sampler: microcode sequencer, four-bank image memory,
// bilinear datapath and APB register file. Depends on pbs_pkg and pbs_ram.
//
// Usage:
//   s_axis carries items; tuser is the op bit (0 pixel write, 1 sample request).
//   A pixel write is stored at once; it returns nothing.
//   A sample request returns one m_axis transfer holding the Q8.16 pattern value.
//   The image sits in four banks split by row and column parity, so one read
//   of the four banks yields a full 2x2 neighborhood.
// Control steps:
//   A sample runs one control step per tap for the nine taps, two steps to drain
//   the read and multiply stages, and one step to load the output register.
//   s_axis tready is low from a sample transfer until the sequencer is back in
//   idle, also while the emit step waits; pixel writes go back to back.
// Reset: arst_n clears the sequencer, pipeline valids and output valid; image_cols and
//   image_rows return to 512. Image contents are undefined until written.
// Stall: the output register holds its result while m_axis tready is low; the
//   next sample is taken but waits in the emit step until that result is taken.
module pattern_bilinear_sampler_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// pixel_row[8:0], pixel_col[17:9], pixel_value[25:18], sample_x[42:26], sample_y[59:43]
	input  logic [pbs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// op[0]
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// sample_value[23:0]
	output logic [pbs_pkg::OUT_W-1:0]         m_axis_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pbs_pkg::APB_AW-1:0]        paddr,
	input  logic [pbs_pkg::APB_DW-1:0]        pwdata,
	output logic [pbs_pkg::APB_DW-1:0]        prdata,
	output logic                              pready
);

	localparam int ROW_W   = pbs_pkg::ROW_W;
	localparam int COL_W   = pbs_pkg::COL_W;
	localparam int INT_W   = pbs_pkg::INT_W;
	localparam int TAPI_W  = pbs_pkg::TAPI_W;
	localparam int EXT_W   = pbs_pkg::EXT_W;
	localparam int FW_W    = pbs_pkg::FW_W;
	localparam int WGT_W   = pbs_pkg::WGT_W;
	localparam int PROD_W  = pbs_pkg::PROD_W;
	localparam int TAP_W   = pbs_pkg::TAP_W;
	localparam int ACC_W   = pbs_pkg::ACC_W;
	localparam int PIX_W   = pbs_pkg::PIX_W;
	localparam int CFG_W   = pbs_pkg::CFG_W;
	localparam int FB      = pbs_pkg::FRAC_BITS;
	localparam int BANK_AW = pbs_pkg::BANK_AW;

	// configuration registers
	logic [CFG_W-1:0]   cols_q, rows_q;
	logic               apb_wr;
	pbs_pkg::reg_idx_t  reg_idx;

	assign pready  = 1'b1;
	assign apb_wr  = psel && penable && pwrite && pready;
	assign reg_idx = pbs_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CFG_W'(512);
			rows_q <= CFG_W'(512);
		end else if (apb_wr) begin
			case (reg_idx)
				pbs_pkg::REG_IMAGE_COLS: cols_q <= pwdata[CFG_W-1:0];
				pbs_pkg::REG_IMAGE_ROWS: rows_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			pbs_pkg::REG_IMAGE_COLS: prdata = pbs_pkg::APB_DW'(cols_q);
			pbs_pkg::REG_IMAGE_ROWS: prdata = pbs_pkg::APB_DW'(rows_q);
			default: prdata = '0;
		endcase
	end

	// sequencer
	logic [pbs_pkg::STEP_W-1:0] step_q, step_d;
	pbs_pkg::uword_t            uw;
	logic                       in_xfer, samp_xfer, wr_xfer;
	logic                       out_vld_q, out_free, emit;

	assign uw            = pbs_pkg::ucode(step_q);
	assign s_axis_tready = (step_q == pbs_pkg::STEP_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign samp_xfer     = in_xfer && s_axis_tuser;
	assign wr_xfer       = in_xfer && !s_axis_tuser;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign emit          = (uw.cond == pbs_pkg::COND_OUT) && out_free;

	always_comb begin
		step_d = step_q;
		case (uw.cond)
			pbs_pkg::COND_NEXT:  step_d = step_q + 1'b1;
			pbs_pkg::COND_START: step_d = samp_xfer ? step_q + 1'b1 : step_q;
			pbs_pkg::COND_OUT:   step_d = out_free ? uw.target : step_q;
			pbs_pkg::COND_JUMP:  step_d = uw.target;
			default:             step_d = pbs_pkg::STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pbs_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// input fields
	logic [pbs_pkg::PIDX_W-1:0]   pix_row, pix_col;
	logic [PIX_W-1:0]             pix_val;
	logic signed [INT_W-1:0]      xb_in, yb_in;
	logic [FB-1:0]                fx_in, fy_in;
	logic [FW_W-1:0]              sfx, sfy, ffx, ffy;

	assign pix_row = s_axis_tdata[pbs_pkg::ROW_LSB +: pbs_pkg::PIDX_W];
	assign pix_col = s_axis_tdata[pbs_pkg::COL_LSB +: pbs_pkg::PIDX_W];
	assign pix_val = s_axis_tdata[pbs_pkg::VAL_LSB +: PIX_W];
	assign xb_in   = s_axis_tdata[pbs_pkg::X_LSB + FB +: INT_W];
	assign yb_in   = s_axis_tdata[pbs_pkg::Y_LSB + FB +: INT_W];
	assign fx_in   = s_axis_tdata[pbs_pkg::X_LSB +: FB];
	assign fy_in   = s_axis_tdata[pbs_pkg::Y_LSB +: FB];
	assign ffx     = FW_W'(fx_in);
	assign ffy     = FW_W'(fy_in);
	assign sfx     = FW_W'(1 << FB) - ffx;
	assign sfy     = FW_W'(1 << FB) - ffy;

	// per-sample state: integer base point and the four bilinear weights
	logic signed [INT_W-1:0] xb_q, yb_q;
	logic [WGT_W-1:0]        wgt_q [4];
	logic [2*FW_W-1:0]       wgt_d [4];

	assign wgt_d[0] = sfx * sfy;
	assign wgt_d[1] = ffx * sfy;
	assign wgt_d[2] = sfx * ffy;
	assign wgt_d[3] = ffx * ffy;

	always_ff @(posedge clk) begin
		if (samp_xfer) begin
			xb_q <= xb_in;
			yb_q <= yb_in;
			for (int k = 0; k < 4; k++) begin
				wgt_q[k] <= wgt_d[k][WGT_W-1:0];
			end
		end
	end

	// tap address generation
	logic signed [TAPI_W-1:0] xi, yi;
	logic [EXT_W-1:0]         cols_eff, rows_eff;
	logic                     tap_ok;
	logic [ROW_W-1:0]         rsel;
	logic [COL_W-1:0]         csel;

	assign xi = TAPI_W'(xb_q) + TAPI_W'(uw.dx);
	assign yi = TAPI_W'(yb_q) + TAPI_W'(uw.dy);

	assign cols_eff = (EXT_W'(cols_q) > EXT_W'(pbs_pkg::MAX_COLS)) ?
		EXT_W'(pbs_pkg::MAX_COLS) : EXT_W'(cols_q);
	assign rows_eff = (EXT_W'(rows_q) > EXT_W'(pbs_pkg::MAX_ROWS)) ?
		EXT_W'(pbs_pkg::MAX_ROWS) : EXT_W'(rows_q);

	assign tap_ok = uw.issue && !xi[TAPI_W-1] && !yi[TAPI_W-1]
		&& (EXT_W'($unsigned(xi)) + EXT_W'(1) < cols_eff)
		&& (EXT_W'($unsigned(yi)) + EXT_W'(1) < rows_eff);

	assign rsel = ROW_W'($unsigned(yi));
	assign csel = COL_W'($unsigned(xi));

	// image banks, indexed {row parity, column parity}
	logic [ROW_W-1:0] wrow;
	logic [COL_W-1:0] wcol;
	logic             wr_in_range;
	logic [PIX_W-1:0] rd [4];

	assign wrow        = ROW_W'(pix_row);
	assign wcol        = COL_W'(pix_col);
	assign wr_in_range = (32'(pix_row) < 32'(pbs_pkg::MAX_ROWS))
		&& (32'(pix_col) < 32'(pbs_pkg::MAX_COLS));

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [ROW_W-1:0]   rr;
		logic [COL_W-1:0]   cc;
		logic [BANK_AW-1:0] raddr, waddr;
		logic               we;

		assign rr    = rsel + ROW_W'(rsel[0] ^ b[1]);
		assign cc    = csel + COL_W'(csel[0] ^ b[0]);
		assign raddr = {rr[ROW_W-1:1], cc[COL_W-1:1]};
		assign waddr = {wrow[ROW_W-1:1], wcol[COL_W-1:1]};
		assign we    = wr_xfer && wr_in_range && (wrow[0] == b[1]) && (wcol[0] == b[0]);

		pbs_ram #(
			.WIDTH (PIX_W),
			.DEPTH (pbs_pkg::BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (pix_val),
			.raddr (raddr),
			.rdata (rd[b])
		);
	end

	// stage 1: bank data returns, reorder into p00, p01, p10, p11
	logic             vld_s1, centre_s1, py_s1, px_s1;
	logic [PIX_W-1:0] pix [4];
	logic [PROD_W-1:0] prod_d [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= tap_ok;
		end
	end

	always_ff @(posedge clk) begin
		centre_s1 <= uw.centre;
		py_s1     <= rsel[0];
		px_s1     <= csel[0];
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			pix[k]    = rd[{py_s1 ^ k[1], px_s1 ^ k[0]}];
			prod_d[k] = PROD_W'(wgt_q[k]) * PROD_W'(pix[k]);
		end
	end

	// stage 2: weighted corners
	logic              vld_s2, centre_s2;
	logic [PROD_W-1:0] prod_s2 [4];
	logic [TAP_W-1:0]  tap_sum;
	logic [ACC_W-1:0]  tap_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		centre_s2 <= centre_s1;
		prod_s2   <= prod_d;
	end

	assign tap_sum = TAP_W'(prod_s2[0]) + TAP_W'(prod_s2[1])
		+ TAP_W'(prod_s2[2]) + TAP_W'(prod_s2[3]);
	assign tap_add = centre_s2 ? (ACC_W'(tap_sum) << 3) : ACC_W'(tap_sum);

	// accumulate: centre counts eight times each neighbor
	logic [ACC_W-1:0]         acc_q;
	logic [pbs_pkg::RES_W-1:0] res_wide;
	logic [pbs_pkg::OUT_W-1:0] out_data_q;

	always_ff @(posedge clk) begin
		if (samp_xfer) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + tap_add;
		end
	end

	assign res_wide = (pbs_pkg::RES_W'(acc_q) << pbs_pkg::RES_SHL) >> pbs_pkg::RES_SHR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= res_wide[pbs_pkg::OUT_W-1:0];
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

FILE: hdl/pbs_check.sv
// Port-level checker for the pattern bilinear sampler, bound to the top level.
// Depends on pbs_pkg; attached to pattern_bilinear_sampler_top by bind.
module pbs_check (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [pbs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input logic                           s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [pbs_pkg::OUT_W-1:0]      m_axis_tdata
);

	logic samp_xfer, wr_xfer;

	assign samp_xfer = s_axis_tvalid && s_axis_tready && s_axis_tuser;
	assign wr_xfer   = s_axis_tvalid && s_axis_tready && !s_axis_tuser;

	a_samp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		samp_xfer |=> !s_axis_tready)
		else $error("input still ready after a sample transfer");

	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		wr_xfer |=> s_axis_tready)
		else $error("input dropped ready after a pixel write");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a sample in progress");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata <= pbs_pkg::OUT_W'(pbs_pkg::OUT_MAX)))
		else $error("result above full-scale Q8.16 value");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result not held");

endmodule

bind pattern_bilinear_sampler_top pbs_check u_pbs_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
